FILE: rtl/core/sxt_pkg.sv
package sxt_pkg;

	// scanner modes
	typedef enum logic [4:0] {
		M_START     = 5'd0,
		M_HALT      = 5'd1,
		M_ZERO      = 5'd2,
		M_HEX       = 5'd3,
		M_DEC       = 5'd4,
		M_ATOM      = 5'd5,
		M_STR       = 5'd6,
		M_STR_ESC   = 5'd7,
		M_STR_X     = 5'd8,
		M_STR_U     = 5'd9,
		M_CHR       = 5'd10,
		M_CHR_ESC   = 5'd11,
		M_CHR_X     = 5'd12,
		M_CHR_U     = 5'd13,
		M_CHR_CLOSE = 5'd14
	} mode_t;

	// token kinds
	typedef enum logic [2:0] {
		TK_OPEN   = 3'd0,
		TK_CLOSE  = 3'd1,
		TK_NUMBER = 3'd2,
		TK_BYTE   = 3'd3,
		TK_EMPTY  = 3'd4,
		TK_DONE   = 3'd5,
		TK_ERROR  = 3'd6
	} kind_t;

	// error codes
	localparam logic [3:0] E_NONE        = 4'd0;
	localparam logic [3:0] E_UNMATCHED_C = 4'd1;
	localparam logic [3:0] E_UNMATCHED_O = 4'd2;
	localparam logic [3:0] E_ZERO_PREFIX = 4'd3;
	localparam logic [3:0] E_HEX_LONG    = 4'd4;
	localparam logic [3:0] E_HEX_DIGITS  = 4'd5;
	localparam logic [3:0] E_DEC_LONG    = 4'd6;
	localparam logic [3:0] E_DEC_DIGITS  = 4'd7;
	localparam logic [3:0] E_STR_OPEN    = 4'd8;
	localparam logic [3:0] E_ESC_OPEN    = 4'd9;
	localparam logic [3:0] E_ESC_X       = 4'd10;
	localparam logic [3:0] E_ESC_U       = 4'd11;
	localparam logic [3:0] E_ESC_CHAR    = 4'd12;
	localparam logic [3:0] E_CHR_MISSING = 4'd13;
	localparam logic [3:0] E_CHR_CLOSE   = 4'd14;
	localparam logic [3:0] E_DEPTH       = 4'd15;

	// most tokens one character can produce
	localparam int unsigned MaxTok = 3;
	localparam int unsigned FifoDepth = 8;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] value;
		logic        last;
		logic [3:0]  code;
		logic [15:0] pos;
		logic [6:0]  depth;
	} tok_t;

	typedef struct packed {
		mode_t       mode;
		logic [6:0]  depth;
		logic [31:0] acc;
		logic [3:0]  dcnt;
		logic [15:0] eacc;
		logic [2:0]  edig;
		logic [7:0]  hb;
		logic        hv;
		logic [15:0] pos;
	} state_t;

	function automatic logic is_blank(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
	endfunction

	function automatic logic is_term(input logic [7:0] c);
		return is_blank(c) || c == 8'h28 || c == 8'h29;
	endfunction

	// hex digit value, 16 when not a digit
	function automatic logic [4:0] hexval(input logic [7:0] c);
		logic [7:0] t;
		t = 8'd16;
		if (c >= 8'h30 && c <= 8'h39) t = c - 8'h30;
		else if (c >= 8'h41 && c <= 8'h46) t = c - 8'h37;
		else if (c >= 8'h61 && c <= 8'h66) t = c - 8'h57;
		return t[4:0];
	endfunction

	function automatic tok_t mk_tok(input kind_t k, input logic [31:0] v, input logic l,
			input logic [3:0] e, input logic [15:0] p, input logic [6:0] d);
		tok_t t;
		t.kind = k;
		t.value = v;
		t.last = l;
		t.code = e;
		t.pos = p;
		t.depth = d;
		return t;
	endfunction

endpackage

FILE: rtl/core/sxt_step.sv
module sxt_step import sxt_pkg::*; #(
	parameter logic [6:0]  DepthLimit = 7'd64,
	parameter logic [15:0] PosLimit = 16'hFFFF
) (
	input  state_t      st,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	output state_t      nx,
	output tok_t        res [MaxTok],
	output logic [1:0]  res_n
);

	logic       do_start;
	logic       esc_fire;
	logic       esc_chr;
	logic [15:0] esc_val;
	logic       halted;
	logic [4:0] h;
	logic [15:0] p;
	logic [7:0] c;
	logic [7:0] eb [3];
	logic [1:0] nb;
	logic [31:0] dec_next;

	// one character through the scanner
	always_comb begin
		nx = st;
		res = '{default: '0};
		res_n = 2'd0;
		do_start = 1'b0;
		esc_fire = 1'b0;
		esc_chr = 1'b0;
		esc_val = 16'd0;
		halted = 1'b0;
		eb = '{default: '0};
		nb = 2'd0;
		c = text_byte;
		h = hexval(c);
		dec_next = (st.acc << 3) + (st.acc << 1) + {24'd0, c - 8'h30};
		p = (st.pos < PosLimit) ? st.pos + 16'd1 : st.pos;
		nx.pos = p;

		if (end_of_text) begin
			// end of text: flush pending token, then done or error
			unique case (st.mode)
				M_HALT: halted = 1'b1;
				M_START: ;
				M_ZERO, M_DEC: begin
					res[res_n] = mk_tok(TK_NUMBER, (st.mode == M_ZERO) ? 32'd0 : st.acc,
						1'b0, E_NONE, p, st.depth);
					res_n = res_n + 2'd1;
				end
				M_HEX: begin
					if (st.dcnt == 4'd0) begin
						res[res_n] = mk_tok(TK_ERROR, 32'd0, 1'b0, E_HEX_DIGITS, p, st.depth);
						res_n = res_n + 2'd1;
						halted = 1'b1;
					end else begin
						res[res_n] = mk_tok(TK_NUMBER, st.acc, 1'b0, E_NONE, p, st.depth);
						res_n = res_n + 2'd1;
					end
				end
				M_ATOM: begin
					res[res_n] = mk_tok(TK_BYTE, {24'd0, st.hb}, 1'b1, E_NONE, p, st.depth);
					res_n = res_n + 2'd1;
				end
				default: begin
					halted = 1'b1;
					res[res_n] = mk_tok(TK_ERROR, 32'd0, 1'b0, E_CHR_CLOSE, p, st.depth);
					case (st.mode)
						M_STR: res[res_n].code = E_STR_OPEN;
						M_STR_ESC, M_CHR_ESC: res[res_n].code = E_ESC_OPEN;
						M_STR_X, M_CHR_X: res[res_n].code = E_ESC_X;
						M_STR_U, M_CHR_U: res[res_n].code = E_ESC_U;
						M_CHR: res[res_n].code = E_CHR_MISSING;
						default: res[res_n].code = E_CHR_CLOSE;
					endcase
					res_n = res_n + 2'd1;
				end
			endcase
			if (!halted) begin
				if (st.depth != 7'd0)
					res[res_n] = mk_tok(TK_ERROR, 32'd0, 1'b0, E_UNMATCHED_O, p, st.depth);
				else
					res[res_n] = mk_tok(TK_DONE, 32'd0, 1'b0, E_NONE, p, st.depth);
				res_n = res_n + 2'd1;
			end
			nx = '0;
			nx.mode = M_START;
		end else begin
			unique case (st.mode)
				M_HALT: ;
				M_START: do_start = 1'b1;
				M_ZERO: begin
					if (is_term(c)) begin
						res[res_n] = mk_tok(TK_NUMBER, 32'd0, 1'b0, E_NONE, p, st.depth);
						res_n = res_n + 2'd1;
						do_start = 1'b1;
					end else if (c == 8'h78) begin
						nx.acc = 32'd0;
						nx.dcnt = 4'd0;
						nx.mode = M_HEX;
					end else begin
						res[res_n] = mk_tok(TK_ERROR, 32'd0, 1'b0, E_ZERO_PREFIX, p, st.depth);
						res_n = res_n + 2'd1;
						nx.mode = M_HALT;
					end
				end
				M_HEX: begin
					if (h < 5'd16) begin
						if (st.dcnt >= 4'd8) begin
							res[res_n] = mk_tok(TK_ERROR, 32'd0, 1'b0, E_HEX_LONG, p, st.depth);
							res_n = res_n + 2'd1;
							nx.mode = M_HALT;
						end else begin
							nx.acc = {st.acc[27:0], h[3:0]};
							nx.dcnt = st.dcnt + 4'd1;
						end
					end else if (is_term(c) && st.dcnt != 4'd0) begin
						res[res_n] = mk_tok(TK_NUMBER, st.acc, 1'b0, E_NONE, p, st.depth);
						res_n = res_n + 2'd1;
						do_start = 1'b1;
					end else begin
						res[res_n] = mk_tok(TK_ERROR, 32'd0, 1'b0, E_HEX_DIGITS, p, st.depth);
						res_n = res_n + 2'd1;
						nx.mode = M_HALT;
					end
				end
				M_DEC: begin
					if (c >= 8'h30 && c <= 8'h39) begin
						if (st.dcnt >= 4'd10) begin
							res[res_n] = mk_tok(TK_ERROR, 32'd0, 1'b0, E_DEC_LONG, p, st.depth);
							res_n = res_n + 2'd1;
							nx.mode = M_HALT;
						end else begin
							nx.acc = dec_next;
							nx.dcnt = st.dcnt + 4'd1;
						end
					end else if (is_term(c)) begin
						res[res_n] = mk_tok(TK_NUMBER, st.acc, 1'b0, E_NONE, p, st.depth);
						res_n = res_n + 2'd1;
						do_start = 1'b1;
					end else begin
						res[res_n] = mk_tok(TK_ERROR, 32'd0, 1'b0, E_DEC_DIGITS, p, st.depth);
						res_n = res_n + 2'd1;
						nx.mode = M_HALT;
					end
				end
				M_ATOM: begin
					if (is_term(c)) begin
						res[res_n] = mk_tok(TK_BYTE, {24'd0, st.hb}, 1'b1, E_NONE, p, st.depth);
						res_n = res_n + 2'd1;
						nx.hv = 1'b0;
						do_start = 1'b1;
					end else begin
						res[res_n] = mk_tok(TK_BYTE, {24'd0, st.hb}, 1'b0, E_NONE, p, st.depth);
						res_n = res_n + 2'd1;
						nx.hb = c;
					end
				end
				M_STR: begin
					if (c == 8'h22) begin
						if (st.hv)
							res[res_n] = mk_tok(TK_BYTE, {24'd0, st.hb}, 1'b1, E_NONE, p,
								st.depth);
						else
							res[res_n] = mk_tok(TK_EMPTY, 32'd0, 1'b0, E_NONE, p, st.depth);
						res_n = res_n + 2'd1;
						nx.hv = 1'b0;
						nx.mode = M_START;
					end else if (c == 8'h5C) begin
						nx.mode = M_STR_ESC;
					end else begin
						if (st.hv) begin
							res[res_n] = mk_tok(TK_BYTE, {24'd0, st.hb}, 1'b0, E_NONE, p,
								st.depth);
							res_n = res_n + 2'd1;
						end
						nx.hb = c;
						nx.hv = 1'b1;
					end
				end
				M_STR_ESC, M_CHR_ESC: begin
					// first character after a backslash
					nx.eacc = 16'd0;
					nx.edig = 3'd0;
					esc_chr = (st.mode == M_CHR_ESC);
					case (c)
						8'h74: begin esc_fire = 1'b1; esc_val = 16'h0009; end
						8'h72: begin esc_fire = 1'b1; esc_val = 16'h000D; end
						8'h30: begin esc_fire = 1'b1; esc_val = 16'h0000; end
						8'h6E: begin esc_fire = 1'b1; esc_val = 16'h000A; end
						8'h22: begin esc_fire = 1'b1; esc_val = 16'h0022; end
						8'h78: nx.mode = esc_chr ? M_CHR_X : M_STR_X;
						8'h75: nx.mode = esc_chr ? M_CHR_U : M_STR_U;
						default: begin
							res[res_n] = mk_tok(TK_ERROR, 32'd0, 1'b0, E_ESC_CHAR, p, st.depth);
							res_n = res_n + 2'd1;
							nx.mode = M_HALT;
						end
					endcase
				end
				M_STR_X, M_STR_U, M_CHR_X, M_CHR_U: begin
					// hex digits of an escape
					esc_chr = (st.mode == M_CHR_X) || (st.mode == M_CHR_U);
					if (h > 5'd15) begin
						res[res_n] = mk_tok(TK_ERROR, 32'd0, 1'b0,
							(st.mode == M_STR_U || st.mode == M_CHR_U) ? E_ESC_U : E_ESC_X,
							p, st.depth);
						res_n = res_n + 2'd1;
						nx.mode = M_HALT;
					end else begin
						nx.eacc = {st.eacc[11:0], h[3:0]};
						nx.edig = st.edig + 3'd1;
						if (nx.edig >= ((st.mode == M_STR_U || st.mode == M_CHR_U) ? 3'd4 : 3'd2))
						begin
							esc_fire = 1'b1;
							esc_val = nx.eacc;
						end
					end
				end
				M_CHR: begin
					if (c == 8'h5C) begin
						nx.mode = M_CHR_ESC;
					end else begin
						nx.acc = {24'd0, c};
						nx.mode = M_CHR_CLOSE;
					end
				end
				default: begin
					if (c == 8'h27) begin
						res[res_n] = mk_tok(TK_NUMBER, st.acc, 1'b0, E_NONE, p, st.depth);
						res_n = res_n + 2'd1;
						nx.mode = M_START;
					end else begin
						res[res_n] = mk_tok(TK_ERROR, 32'd0, 1'b0, E_CHR_CLOSE, p, st.depth);
						res_n = res_n + 2'd1;
						nx.mode = M_HALT;
					end
				end
			endcase

			// finished escape: char literal value or utf-8 bytes
			if (esc_fire) begin
				if (esc_chr) begin
					nx.acc = {16'd0, esc_val};
					nx.mode = M_CHR_CLOSE;
				end else begin
					if (esc_val <= 16'h007F) begin
						eb[0] = esc_val[7:0];
						nb = 2'd1;
					end else if (esc_val <= 16'h07FF) begin
						eb[0] = {3'b110, esc_val[10:6]};
						eb[1] = {2'b10, esc_val[5:0]};
						nb = 2'd2;
					end else begin
						eb[0] = {4'b1110, esc_val[15:12]};
						eb[1] = {2'b10, esc_val[11:6]};
						eb[2] = {2'b10, esc_val[5:0]};
						nb = 2'd3;
					end
					for (int i = 0; i < 3; i++) begin
						if (2'(i) < nb) begin
							if (nx.hv) begin
								res[res_n] = mk_tok(TK_BYTE, {24'd0, nx.hb}, 1'b0, E_NONE, p,
									nx.depth);
								res_n = res_n + 2'd1;
							end
							nx.hb = eb[i];
							nx.hv = 1'b1;
						end
					end
					nx.mode = M_STR;
				end
			end

			// character that begins a new token
			if (do_start) begin
				nx.mode = M_START;
				if (c == 8'h28) begin
					if (nx.depth >= DepthLimit) begin
						res[res_n] = mk_tok(TK_ERROR, 32'd0, 1'b0, E_DEPTH, p, nx.depth);
						res_n = res_n + 2'd1;
						nx.mode = M_HALT;
					end else begin
						nx.depth = nx.depth + 7'd1;
						res[res_n] = mk_tok(TK_OPEN, 32'd0, 1'b0, E_NONE, p, nx.depth);
						res_n = res_n + 2'd1;
					end
				end else if (c == 8'h29) begin
					if (nx.depth == 7'd0) begin
						res[res_n] = mk_tok(TK_ERROR, 32'd0, 1'b0, E_UNMATCHED_C, p, nx.depth);
						res_n = res_n + 2'd1;
						nx.mode = M_HALT;
					end else begin
						nx.depth = nx.depth - 7'd1;
						res[res_n] = mk_tok(TK_CLOSE, 32'd0, 1'b0, E_NONE, p, nx.depth);
						res_n = res_n + 2'd1;
					end
				end else if (is_blank(c)) begin
					nx.mode = M_START;
				end else if (c == 8'h30) begin
					nx.mode = M_ZERO;
				end else if (c >= 8'h31 && c <= 8'h39) begin
					nx.acc = {24'd0, c - 8'h30};
					nx.dcnt = 4'd1;
					nx.mode = M_DEC;
				end else if (c == 8'h22) begin
					nx.hv = 1'b0;
					nx.mode = M_STR;
				end else if (c == 8'h27) begin
					nx.mode = M_CHR;
				end else begin
					nx.hb = c;
					nx.hv = 1'b1;
					nx.mode = M_ATOM;
				end
			end
		end
	end

endmodule

FILE: rtl/core/sxt_fifo.sv
module sxt_fifo import sxt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] wr_n,
	input  tok_t       wr_data [MaxTok],
	input  logic       rd,
	output tok_t       rd_data,
	output logic       not_empty,
	output logic [3:0] free
);

	localparam int unsigned PtrW = $clog2(FifoDepth);

	tok_t            mem_q [FifoDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [3:0]      count_q;

	assign not_empty = (count_q != 4'd0);
	assign free = 4'(FifoDepth) - count_q;
	assign rd_data = mem_q[rd_ptr_q];

	// token storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < MaxTok; i++) begin
			if (2'(i) < wr_n)
				mem_q[wr_ptr_q + PtrW'(i)] <= wr_data[i];
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PtrW'(wr_n);
			if (rd)
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			count_q <= count_q + {2'd0, wr_n} - {3'd0, rd};
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		{2'd0, wr_n} <= free)
		else $error("token queue overflow");
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 4'(FifoDepth))
		else $error("token queue level out of range");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> not_empty)
		else $error("token queue read while empty");
`endif

endmodule

FILE: rtl/core/sexpr_tokenizer.sv
// S-expression tokenizer. Takes one text byte (or an end marker) per request
// and emits open, close, number, string/atom byte, empty string, done and
// error tokens in text order. One request is taken every cycle while text_stall
// is low: the byte goes through an input register and a single pass of scanner
// logic, and the zero to three tokens it yields go into an eight-entry token
// queue that drains one token per cycle while token_stall is low. Input stalls
// only while the queue has fewer than three free entries, so long bursts of
// multi-token characters (escape sequences, a number closed by a parenthesis,
// the end marker) slow the input. After an error no tokens come until the end
// marker, which then clears all state for the next text.
module sexpr_tokenizer import sxt_pkg::*; #(
	parameter int unsigned     MAX_DEPTH = 64,
	parameter longint unsigned MAX_TEXT_LENGTH = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	output logic        text_stall,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	output logic        token_valid,
	input  logic        token_stall,
	output logic [2:0]  token_kind,
	output logic [31:0] token_value,
	output logic        last_byte,
	output logic [3:0]  error_code,
	output logic [15:0] char_position,
	output logic [6:0]  nest_depth
);

	localparam logic [6:0] DepthLimit = (MAX_DEPTH < 127) ? 7'(MAX_DEPTH) : 7'd127;
	localparam logic [15:0] PosLimit =
		(MAX_TEXT_LENGTH < 64'hFFFF) ? 16'(MAX_TEXT_LENGTH) : 16'hFFFF;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;
	logic       advance;
	logic       accept;
	state_t     state_q;
	state_t     state_nx;
	tok_t       res [MaxTok];
	logic [1:0] res_n;
	logic [1:0] wr_n;
	tok_t       head;
	logic [3:0] free;

	assign advance = valid_s1 && (free >= 4'(MaxTok));
	assign text_stall = valid_s1 && !advance;
	assign accept = text_valid && !text_stall;
	assign wr_n = advance ? res_n : 2'd0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= text_byte;
			eot_s1 <= end_of_text;
		end
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nx;
		end
	end

	sxt_step #(
		.DepthLimit(DepthLimit),
		.PosLimit(PosLimit)
	) u_step (
		.st(state_q),
		.text_byte(byte_s1),
		.end_of_text(eot_s1),
		.nx(state_nx),
		.res(res),
		.res_n(res_n)
	);

	sxt_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_n(wr_n),
		.wr_data(res),
		.rd(token_valid && !token_stall),
		.rd_data(head),
		.not_empty(token_valid),
		.free(free)
	);

	// token fields
	assign token_kind = head.kind;
	assign token_value = head.value;
	assign last_byte = head.last;
	assign error_code = head.code;
	assign char_position = head.pos;
	assign nest_depth = head.depth;

`ifndef ASSERT_OFF
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		text_stall |-> valid_s1)
		else $error("input stalled with empty input register");
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.depth <= DepthLimit)
		else $error("nesting depth beyond limit");
	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && state_q.mode == M_HALT) |-> res_n == 2'd0)
		else $error("token produced while halted");
`endif

endmodule
